/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define CFS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define CFS_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define CFS_ASSERT(lbl, clk, rst_n, prop)

`define CFS_ASSERT_NR(lbl, clk, prop)

`endif

`endif

/* rtl/cfs_pkg.sv */
// ----------------------------------------------------------------------------
// cfs_pkg
// Widths, fixed-point constants, latencies and register indexes.
// ----------------------------------------------------------------------------
package cfs_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int STEP_FRAC  = 24;
  localparam int TANH_Q     = 30;
  localparam int TANH_DOUBLINGS = 10;

  localparam int POS_W   = 30;
  localparam int W24     = 24;
  localparam int RING_W  = 14;
  localparam int CFG_IDX_W = 2;

  localparam logic [W24-1:0]    TS_RESET   = 24'd16777;
  localparam logic [RING_W-1:0] RING_RESET = 14'd10000;

  localparam int THETA_QW   = 34;
  localparam int BRAKE_QW   = 48;
  localparam int TDIV_QW    = 31;
  localparam int TDIV_DW    = 32;

  localparam logic [THETA_QW:0] THETA_LIMIT = 35'd1 << THETA_QW;
  localparam logic [16:0] THIRD_RECIP = 17'd43691;
  localparam int THIRD_SHIFT = 17;

  localparam int THETA_LAT = THETA_QW;
  localparam int TANH_LAT  = 3 + TANH_DOUBLINGS * (TDIV_QW + 1);
  localparam int BRAKE_LAT = BRAKE_QW;
  localparam int LAT_TOTAL = 3 + THETA_LAT + TANH_LAT + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP   = 2'd0,
    REG_RING_LENGTH = 2'd1
  } cfg_reg_e;

endpackage

/* rtl/car_following_step.sv */
// ----------------------------------------------------------------------------
// car_following_step
// One car-following update: collision-time braking or tanh law, then step.
// ----------------------------------------------------------------------------
// Takes one word per clock and delivers one result word per clock while the
// skid stage is empty. The depth from acceptance to the output register is
// set by the tanh unit, ten doublings of one 31-stage divider each, behind the
// 34-stage divider that forms the tanh argument. The braking divider runs
// in parallel and is delayed to match. A finished word waits in the output
// register with a one-word skid stage behind it; the pipeline stalls only
// when both are full.
`include "assert_macros.svh"

module car_following_step (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cfs_pkg::W24-1:0]          cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cfs_pkg::POS_W-1:0]        own_position_i,
  input  logic signed [cfs_pkg::W24-1:0]   own_speed_i,
  input  logic [cfs_pkg::POS_W-1:0]        leader_position_i,
  input  logic signed [cfs_pkg::W24-1:0]   leader_speed_i,
  input  logic [cfs_pkg::W24-1:0]          body_length_i,
  input  logic [cfs_pkg::W24-1:0]          reaction_time_i,
  input  logic [cfs_pkg::W24-1:0]          brake_gain_i,
  input  logic [cfs_pkg::W24-1:0]          desired_speed_i,
  input  logic [cfs_pkg::W24-1:0]          steepness_i,
  input  logic [cfs_pkg::W24-1:0]          max_accel_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cfs_pkg::POS_W-1:0]        new_position_o,
  output logic signed [cfs_pkg::W24-1:0]   new_speed_o,
  output logic signed [cfs_pkg::W24-1:0]   acceleration_o,
  output logic                             braking_branch_o,
  output logic                             saturated_o
);
  import cfs_pkg::*;

  localparam int SIDE_W   = 2 + W24 + POS_W;
  localparam int SIDE_D   = THETA_LAT + TANH_LAT + 1;
  localparam int AMAX_D   = THETA_LAT + TANH_LAT;
  localparam int ACCB_D   = SIDE_D - BRAKE_LAT - 2;
  localparam logic [23:0] ACC_MAXV = 24'h7FFFFF;
  localparam logic [23:0] ACC_MINV = 24'h800000;

  // configuration
  logic [W24-1:0]    ts_q;
  logic [RING_W-1:0] ring_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q   <= TS_RESET;
      ring_q <= RING_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TIME_STEP:   ts_q   <= cfg_wdata_i;
        REG_RING_LENGTH: ring_q <= cfg_wdata_i[RING_W-1:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic                 en;
  logic [LAT_TOTAL-1:0] vld_q;
  logic                 skid_valid_q, out_valid_q;

  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT_TOTAL-2:0], in_valid_i};
    end
  end

  logic signed [31:0] ring_f;
  assign ring_f = $signed(32'({ring_q, {FRAC_BITS{1'b0}}}));

  // stage A
  logic signed [31:0] gap0, gap, n0, nabs;
  logic signed [24:0] c0;
  logic signed [25:0] diff;
  logic signed [48:0] pos_prod;
  logic               cneg, dneg;

  assign gap0 = $signed({2'b0, leader_position_i}) - $signed({2'b0, own_position_i});
  assign gap  = gap0[31] ? gap0 + ring_f : gap0;
  assign n0   = gap - $signed({8'b0, body_length_i});
  assign c0   = $signed({own_speed_i[23], own_speed_i})
              - $signed({leader_speed_i[23], leader_speed_i});
  assign cneg = c0[24];
  assign nabs = cneg ? -n0 : n0;
  assign diff = $signed({2'b0, desired_speed_i})
              - $signed({{2{own_speed_i[23]}}, own_speed_i});
  assign dneg = diff[25];
  assign pos_prod = $signed({1'b0, ts_q}) * own_speed_i;

  logic signed [31:0] a_n_q;
  logic [23:0]        a_cmag_q, a_tao_q, a_alpha_q, a_steep_q, a_amax_q;
  logic [24:0]        a_ad_q;
  logic               a_dneg_q;
  logic [POS_W-1:0]   a_pos_q;
  logic signed [23:0] a_speed_q;
  logic signed [24:0] a_step_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_n_q     <= nabs;
      a_cmag_q  <= cneg ? 24'(-c0) : c0[23:0];
      a_tao_q   <= reaction_time_i;
      a_alpha_q <= brake_gain_i;
      a_ad_q    <= 25'(dneg ? -diff : diff);
      a_dneg_q  <= dneg;
      a_steep_q <= (steepness_i == '0) ? 24'd1 : steepness_i;
      a_amax_q  <= max_accel_i;
      a_pos_q   <= own_position_i;
      a_speed_q <= own_speed_i;
      a_step_q  <= pos_prod[48:STEP_FRAC];
    end
  end

  // stage B
  logic signed [31:0] np0, npw;
  assign np0 = $signed({2'b0, a_pos_q}) + $signed({{7{a_step_q[24]}}, a_step_q});
  assign npw = (np0 >= ring_f) ? np0 - ring_f : (np0[31] ? np0 + ring_f : np0);

  logic signed [31:0] b_n_q;
  logic [47:0]        b_tc_q;
  logic               b_big_q, b_dneg_q;
  logic [24:0]        b_ad_q;
  logic [23:0]        b_steep_q, b_alpha_q, b_amax_q;
  logic signed [23:0] b_speed_q;
  logic [POS_W-1:0]   b_pos_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_n_q     <= a_n_q;
      b_tc_q    <= a_tao_q * a_cmag_q;
      b_big_q   <= 28'(a_ad_q) >= {a_steep_q, 4'b0};
      b_ad_q    <= a_ad_q;
      b_steep_q <= a_steep_q;
      b_dneg_q  <= a_dneg_q;
      b_alpha_q <= a_alpha_q;
      b_amax_q  <= a_amax_q;
      b_speed_q <= a_speed_q;
      b_pos_q   <= npw[POS_W-1:0];
    end
  end

  // stage C
  logic               c_brake_q, c_big_q, c_dneg_q;
  logic [47:0]        c_tc_q;
  logic [30:0]        c_den_q;
  logic [24:0]        c_ad_q;
  logic [23:0]        c_steep_q, c_alpha_q, c_amax_q;
  logic signed [23:0] c_speed_q;
  logic [POS_W-1:0]   c_pos_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_brake_q <= !b_n_q[31] && (b_n_q != 0)
                && ((48'(b_n_q[30:0]) << FRAC_BITS) < b_tc_q);
      c_tc_q    <= b_tc_q;
      c_den_q   <= b_n_q[30:0];
      c_ad_q    <= b_ad_q;
      c_steep_q <= b_steep_q;
      c_big_q   <= b_big_q;
      c_dneg_q  <= b_dneg_q;
      c_alpha_q <= b_alpha_q;
      c_amax_q  <= b_amax_q;
      c_speed_q <= b_speed_q;
      c_pos_q   <= b_pos_q;
    end
  end

  // braking path
  logic [BRAKE_QW-1:0] br_r, br_d;
  logic [23:0]         alpha_d;

  cfs_div #(.QW(BRAKE_QW), .DW(31)) u_brake_div (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i ('0),
    .num_i (c_tc_q),
    .den_i (c_den_q),
    .quo_o (br_r)
  );

  cfs_delay #(.W(24), .D(BRAKE_LAT)) u_alpha_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (c_alpha_q),
    .q_o   (alpha_d)
  );

  assign br_d = br_r - (BRAKE_QW'(1) << FRAC_BITS);

  logic [47:0] bm_hi_q;
  logic [39:0] bm_lo_q;
  logic        bm_over_q;
  logic [48:0] bs_mag;
  logic        bs_sat;
  logic [23:0] bs_acc_q;
  logic        bs_sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bm_hi_q   <= alpha_d * br_d[FRAC_BITS +: 24];
      bm_lo_q   <= alpha_d * br_d[FRAC_BITS-1:0];
      bm_over_q <= ((br_d >> (FRAC_BITS + 24)) != '0) && (alpha_d != '0);
    end
  end

  assign bs_mag = 49'(bm_hi_q) + 49'(bm_lo_q >> FRAC_BITS);
  assign bs_sat = bm_over_q || (bs_mag > 49'h800000);

  always_ff @(posedge clk_i) begin
    if (en) begin
      bs_acc_q <= bs_sat ? ACC_MINV : 24'(49'd0 - bs_mag);
      bs_sat_q <= bs_sat;
    end
  end

  // tanh path
  logic [THETA_QW-1:0] th_q;
  logic                big_d;
  logic [THETA_QW:0]   theta;
  logic [TDIV_QW-1:0]  tanh_t;
  logic [23:0]         amax_d;

  cfs_div #(.QW(THETA_QW), .DW(24)) u_theta_div (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (24'(c_ad_q >> 4)),
    .num_i ({c_ad_q[3:0], {TANH_Q{1'b0}}}),
    .den_i (c_steep_q),
    .quo_o (th_q)
  );

  cfs_delay #(.W(1), .D(THETA_LAT)) u_big_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (c_big_q),
    .q_o   (big_d)
  );

  assign theta = big_d ? THETA_LIMIT : {1'b0, th_q};

  cfs_tanh u_tanh (
    .clk_i   (clk_i),
    .en_i    (en),
    .theta_i (theta),
    .tanh_o  (tanh_t)
  );

  cfs_delay #(.W(24), .D(AMAX_D)) u_amax_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (c_amax_q),
    .q_o   (amax_d)
  );

  logic [54:0] m_prod;
  logic [23:0] m_mag_q;
  assign m_prod = amax_d * tanh_t;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_mag_q <= 24'(m_prod >> TANH_Q);
    end
  end

  // merge
  logic [SIDE_W-1:0] side_d;
  logic [24:0]       accb_d;

  cfs_delay #(.W(SIDE_W), .D(SIDE_D)) u_side_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({c_brake_q, c_dneg_q, c_speed_q, c_pos_q}),
    .q_o   (side_d)
  );

  cfs_delay #(.W(25), .D(ACCB_D)) u_accb_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({bs_sat_q, bs_acc_q}),
    .q_o   (accb_d)
  );

  logic               sd_brake, sd_dneg;
  logic [23:0]        sd_speed;
  logic [POS_W-1:0]   sd_pos;
  logic [23:0]        t_acc;
  logic               t_sat;

  assign {sd_brake, sd_dneg, sd_speed, sd_pos} = side_d;

  always_comb begin
    t_sat = 1'b0;
    if (sd_dneg) begin
      if (m_mag_q > ACC_MINV) begin
        t_acc = ACC_MINV;
        t_sat = 1'b1;
      end else begin
        t_acc = 24'(-m_mag_q);
      end
    end else begin
      if (m_mag_q > ACC_MAXV) begin
        t_acc = ACC_MAXV;
        t_sat = 1'b1;
      end else begin
        t_acc = m_mag_q;
      end
    end
  end

  logic signed [23:0] s_acc_q, s_speed_q;
  logic               s_sat_q, s_brake_q;
  logic [POS_W-1:0]   s_pos_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_acc_q   <= sd_brake ? accb_d[23:0] : t_acc;
      s_sat_q   <= sd_brake ? accb_d[24] : t_sat;
      s_brake_q <= sd_brake;
      s_speed_q <= sd_speed;
      s_pos_q   <= sd_pos;
    end
  end

  // speed step
  logic signed [48:0] acc_prod;
  assign acc_prod = $signed({1'b0, ts_q}) * s_acc_q;

  logic signed [24:0] p_step_q;
  logic signed [23:0] p_acc_q, p_speed_q;
  logic               p_sat_q, p_brake_q;
  logic [POS_W-1:0]   p_pos_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_step_q  <= acc_prod[48:STEP_FRAC];
      p_acc_q   <= s_acc_q;
      p_speed_q <= s_speed_q;
      p_sat_q   <= s_sat_q;
      p_brake_q <= s_brake_q;
      p_pos_q   <= s_pos_q;
    end
  end

  logic signed [25:0] nv0;
  logic signed [23:0] nv;
  logic               nv_sat;

  assign nv0 = $signed({{2{p_speed_q[23]}}, p_speed_q}) + $signed({p_step_q[24], p_step_q});

  always_comb begin
    nv_sat = 1'b0;
    nv     = nv0[23:0];
    if (nv0 > $signed(26'sh7FFFFF)) begin
      nv     = ACC_MAXV;
      nv_sat = 1'b1;
    end else if (nv0 < $signed(-26'sh800000)) begin
      nv     = ACC_MINV;
      nv_sat = 1'b1;
    end
  end

  logic signed [23:0] n_speed_q, n_acc_q;
  logic               n_sat_q, n_brake_q;
  logic [POS_W-1:0]   n_pos_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_speed_q <= nv;
      n_acc_q   <= p_acc_q;
      n_sat_q   <= p_sat_q | nv_sat;
      n_brake_q <= p_brake_q;
      n_pos_q   <= p_pos_q;
    end
  end

  // output register and skid
  logic               fin_valid, out_free;
  logic [POS_W-1:0]   out_pos_q, skid_pos_q;
  logic signed [23:0] out_speed_q, skid_speed_q, out_acc_q, skid_acc_q;
  logic               out_brake_q, skid_brake_q, out_sat_q, skid_sat_q;

  assign fin_valid = en && vld_q[LAT_TOTAL-1];
  assign out_free  = out_ready_i || !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= fin_valid;
      end
    end else if (fin_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_pos_q   <= skid_pos_q;
        out_speed_q <= skid_speed_q;
        out_acc_q   <= skid_acc_q;
        out_brake_q <= skid_brake_q;
        out_sat_q   <= skid_sat_q;
      end else if (fin_valid) begin
        out_pos_q   <= n_pos_q;
        out_speed_q <= n_speed_q;
        out_acc_q   <= n_acc_q;
        out_brake_q <= n_brake_q;
        out_sat_q   <= n_sat_q;
      end
    end else if (fin_valid) begin
      skid_pos_q   <= n_pos_q;
      skid_speed_q <= n_speed_q;
      skid_acc_q   <= n_acc_q;
      skid_brake_q <= n_brake_q;
      skid_sat_q   <= n_sat_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign new_position_o   = out_pos_q;
  assign new_speed_o      = out_speed_q;
  assign acceleration_o   = out_acc_q;
  assign braking_branch_o = out_brake_q;
  assign saturated_o      = out_sat_q;

  `CFS_ASSERT(a_skid_behind_out, clk_i, rst_ni, skid_valid_q |-> out_valid_q)
  `CFS_ASSERT(a_skid_drains, clk_i, rst_ni, (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
  `CFS_ASSERT(a_brake_sign, clk_i, rst_ni, (out_valid_q && out_brake_q) |-> (out_acc_q[23] || out_acc_q == 0))

endmodule

/* rtl/cfs_div.sv */
// ----------------------------------------------------------------------------
// cfs_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cfs_div #(
  parameter int QW = 8,
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] nq_q  [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] nq_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign nq_in  = num_i;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign nq_in  = nq_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign trial = {rem_in, nq_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        nq_q[k]  <= {nq_in[QW-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = nq_q[QW-1];

endmodule

/* rtl/cfs_delay.sv */
// ----------------------------------------------------------------------------
// cfs_delay
// Enabled delay line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module cfs_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] dly_q [D];

  for (genvar k = 0; k < D; k++) begin : g_tap
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (k == 0) begin
          dly_q[k] <= d_i;
        end else begin
          dly_q[k] <= dly_q[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  assign q_o = dly_q[D-1];

endmodule

/* rtl/cfs_tanh.sv */
// ----------------------------------------------------------------------------
// cfs_tanh
// Q.30 tanh: cubic start on the argument over 1024, then ten doublings.
// ----------------------------------------------------------------------------
module cfs_tanh (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [cfs_pkg::THETA_QW:0] theta_i,
  output logic [cfs_pkg::TDIV_QW-1:0] tanh_o
);
  import cfs_pkg::*;

  logic [24:0] u;
  logic [49:0] usq;
  logic [24:0] u1_q, u2_q;
  logic [18:0] sq1_q;
  logic [43:0] cube;
  logic [12:0] c3_q;
  logic [29:0] third_p;
  logic [12:0] third;
  logic [TDIV_QW-1:0] t0_q;

  logic [TDIV_QW-1:0] tm_q  [TANH_DOUBLINGS];
  logic [TDIV_DW-1:0] den_q [TANH_DOUBLINGS];
  logic [TDIV_QW-1:0] tq    [TANH_DOUBLINGS];

  assign u   = theta_i[THETA_QW:10];
  assign usq = u * u;
  assign cube = sq1_q * u1_q;
  assign third_p = c3_q * THIRD_RECIP;
  assign third = 13'(third_p >> THIRD_SHIFT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q  <= u;
      sq1_q <= 19'(usq >> TANH_Q);
      u2_q  <= u1_q;
      c3_q  <= 13'(cube >> TANH_Q);
      t0_q  <= TDIV_QW'(u2_q) - TDIV_QW'(third);
    end
  end

  for (genvar i = 0; i < TANH_DOUBLINGS; i++) begin : g_dbl
    logic [TDIV_QW-1:0]     t_in;
    logic [2*TDIV_QW-1:0]   tsq;

    if (i == 0) begin : g_first
      assign t_in = t0_q;
    end else begin : g_next
      assign t_in = tq[(i == 0) ? 0 : i-1];
    end

    assign tsq = t_in * t_in;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        tm_q[i]  <= t_in;
        den_q[i] <= (TDIV_DW'(1) << TANH_Q) + TDIV_DW'(tsq >> TANH_Q);
      end
    end

    cfs_div #(
      .QW (TDIV_QW),
      .DW (TDIV_DW)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .rem_i (TDIV_DW'(tm_q[i])),
      .num_i ('0),
      .den_i (den_q[i]),
      .quo_o (tq[i])
    );
  end

  assign tanh_o = tq[TANH_DOUBLINGS-1];

endmodule

/* tb/car_following_checker.sv */
// ----------------------------------------------------------------------------
// car_following_checker
// Watches the configuration port and both word channels of the car-following
// step. For every accepted input word it computes the expected update with
// its own fixed-point model and queues it. Each accepted output word is
// compared field by field with the oldest queued update.
// ----------------------------------------------------------------------------
module car_following_checker
  import cfs_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [W24-1:0]         cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [POS_W-1:0]       own_position_i,
  input  logic signed [W24-1:0]  own_speed_i,
  input  logic [POS_W-1:0]       leader_position_i,
  input  logic signed [W24-1:0]  leader_speed_i,
  input  logic [W24-1:0]         body_length_i,
  input  logic [W24-1:0]         reaction_time_i,
  input  logic [W24-1:0]         brake_gain_i,
  input  logic [W24-1:0]         desired_speed_i,
  input  logic [W24-1:0]         steepness_i,
  input  logic [W24-1:0]         max_accel_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic [POS_W-1:0]       new_position_i,
  input  logic signed [W24-1:0]  new_speed_i,
  input  logic signed [W24-1:0]  acceleration_i,
  input  logic                   braking_branch_i,
  input  logic                   saturated_i,
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [POS_W-1:0]      position;
    logic signed [W24-1:0] speed;
    logic signed [W24-1:0] accel;
    logic                  brake;
    logic                  sat;
  } car_update_t;

  localparam longint ACC_HI = 64'sd8388607;
  localparam longint ACC_LO = -64'sd8388608;

  logic [W24-1:0]    step_q;
  logic [RING_W-1:0] ring_q;
  car_update_t       updates_q[$];

  function automatic longint clip_w24(longint v, inout logic flag);
    if (v > ACC_HI) begin
      flag = 1'b1;
      return ACC_HI;
    end
    if (v < ACC_LO) begin
      flag = 1'b1;
      return ACC_LO;
    end
    return v;
  endfunction

  function automatic longint unsigned tanh_fix(longint unsigned x);
    longint unsigned one;
    longint unsigned u;
    longint unsigned t;
    longint unsigned sq;
    one = 64'd1 << TANH_Q;
    if (x > (64'd16 << TANH_Q)) x = 64'd16 << TANH_Q;
    u = x >> TANH_DOUBLINGS;
    t = u - ((((u * u) >> TANH_Q) * u) >> TANH_Q) / 3;
    for (int i = 0; i < TANH_DOUBLINGS; i++) begin
      sq = (t * t) >> TANH_Q;
      t = (t << (TANH_Q + 1)) / (one + sq);
    end
    return t;
  endfunction

  function automatic car_update_t advance_car();
    car_update_t res;
    longint own_pos, lead_pos, own_v, lead_v, ringq, gap, n, c, acc, nv, np;
    longint tao, alpha, want, steep, amax, r, d, mag, diff, ad;
    logic sat;
    logic brake;
    sat = 1'b0;
    brake = 1'b0;
    own_pos = longint'(own_position_i);
    lead_pos = longint'(leader_position_i);
    own_v = longint'(own_speed_i);
    lead_v = longint'(leader_speed_i);
    tao = longint'(reaction_time_i);
    alpha = longint'(brake_gain_i);
    want = longint'(desired_speed_i);
    steep = longint'(steepness_i);
    amax = longint'(max_accel_i);
    ringq = longint'(ring_q) << FRAC_BITS;
    gap = lead_pos - own_pos;
    if (gap < 0) gap += ringq;
    n = gap - longint'(body_length_i);
    c = own_v - lead_v;
    if (c < 0) begin
      n = -n;
      c = -c;
    end
    if (c != 0 && n > 0 && (n << FRAC_BITS) < tao * c) begin
      r = (tao * c) / n;
      d = r - (64'sd1 << FRAC_BITS);
      mag = alpha * (d >> FRAC_BITS) + ((alpha * (d & 64'hFFFF)) >> FRAC_BITS);
      brake = 1'b1;
      if (mag > 64'sd8388608) begin
        sat = 1'b1;
        acc = ACC_LO;
      end else begin
        acc = -mag;
      end
    end else begin
      diff = want - own_v;
      ad = (diff < 0) ? -diff : diff;
      if (steep == 0) steep = 1;
      mag = longint'((longint'(amax) * tanh_fix((ad << TANH_Q) / steep)) >> TANH_Q);
      acc = clip_w24((diff < 0) ? -mag : mag, sat);
    end
    nv = clip_w24(own_v + ((longint'(step_q) * acc) >>> STEP_FRAC), sat);
    np = own_pos + ((longint'(step_q) * own_v) >>> STEP_FRAC);
    if (np >= ringq) np -= ringq;
    else if (np < 0) np += ringq;
    res.position = np[POS_W-1:0];
    res.speed = nv[W24-1:0];
    res.accel = acc[W24-1:0];
    res.brake = brake;
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d", field, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
  end

  assign pending_o = updates_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    car_update_t want;
    if (!rst_ni) begin
      step_q <= TS_RESET;
      ring_q <= RING_RESET;
    end else begin
      if (in_valid_i && in_ready_i) updates_q.push_back(advance_car());
      if (out_valid_i && out_ready_i) begin
        if (updates_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = updates_q.pop_front();
          if (new_position_i !== want.position)
            report_mismatch("new_position", new_position_i, want.position);
          if (new_speed_i !== want.speed)
            report_mismatch("new_speed", new_speed_i, want.speed);
          if (acceleration_i !== want.accel)
            report_mismatch("acceleration", acceleration_i, want.accel);
          if (braking_branch_i !== want.brake)
            report_mismatch("braking_branch", braking_branch_i, want.brake);
          if (saturated_i !== want.sat)
            report_mismatch("saturated", saturated_i, want.sat);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_TIME_STEP) step_q <= cfg_wdata_i;
        else if (cfg_idx_i == REG_RING_LENGTH) ring_q <= cfg_wdata_i[RING_W-1:0];
      end
    end
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the car-following step with directed and random car words under
// several time step and ring length settings, with random idling on both
// channels and one long output hold-off. A checker beside the block does
// the prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import cfs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_WORDS = 900;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [W24-1:0]        cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [POS_W-1:0]      own_position_i;
  logic signed [W24-1:0] own_speed_i;
  logic [POS_W-1:0]      leader_position_i;
  logic signed [W24-1:0] leader_speed_i;
  logic [W24-1:0]        body_length_i;
  logic [W24-1:0]        reaction_time_i;
  logic [W24-1:0]        brake_gain_i;
  logic [W24-1:0]        desired_speed_i;
  logic [W24-1:0]        steepness_i;
  logic [W24-1:0]        max_accel_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [POS_W-1:0]      new_position_o;
  logic signed [W24-1:0] new_speed_o;
  logic signed [W24-1:0] acceleration_o;
  logic                  braking_branch_o;
  logic                  saturated_o;
  int                    errors;
  int                    pending;
  int                    idle_cycles;
  bit                    quiet;
  bit                    hold_req;

  car_following_step dut (.*);

  car_following_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .own_position_i, .own_speed_i, .leader_position_i, .leader_speed_i,
    .body_length_i, .reaction_time_i, .brake_gain_i, .desired_speed_i,
    .steepness_i, .max_accel_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .new_position_i(new_position_o), .new_speed_i(new_speed_o),
    .acceleration_i(acceleration_o), .braking_branch_i(braking_branch_o),
    .saturated_i(saturated_o),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on channel activity
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (900) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [W24-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  // drive one word; caller has set the fields through the arguments
  task automatic send_car(logic [POS_W-1:0] op, logic [W24-1:0] ov, logic [POS_W-1:0] lp,
                          logic [W24-1:0] lv, logic [W24-1:0] bl, logic [W24-1:0] rt,
                          logic [W24-1:0] bg, logic [W24-1:0] ds, logic [W24-1:0] st,
                          logic [W24-1:0] ma);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    own_position_i <= op;
    own_speed_i <= ov;
    leader_position_i <= lp;
    leader_speed_i <= lv;
    body_length_i <= bl;
    reaction_time_i <= rt;
    brake_gain_i <= bg;
    desired_speed_i <= ds;
    steepness_i <= st;
    max_accel_i <= ma;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic lower_valid();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // mostly plausible traffic with a share of fully random words
  task automatic send_random(int ring_m);
    logic [POS_W-1:0] op, lp;
    logic [W24-1:0] ov, lv;
    int unsigned ringq;
    ringq = ring_m << FRAC_BITS;
    if ($urandom_range(0, 4) == 0) begin
      send_car(POS_W'($urandom), W24'($urandom), POS_W'($urandom), W24'($urandom),
               W24'($urandom), W24'($urandom), W24'($urandom), W24'($urandom),
               W24'($urandom), W24'($urandom));
    end else begin
      op = POS_W'($urandom_range(0, ringq - 1));
      lp = POS_W'(op + $urandom_range(0, 60 << FRAC_BITS));
      if (lp >= ringq) lp = POS_W'(lp - ringq);
      ov = W24'($urandom_range(0, 40 << FRAC_BITS) - (5 << FRAC_BITS));
      lv = W24'(ov - $urandom_range(0, 20 << FRAC_BITS) + (5 << FRAC_BITS));
      send_car(op, ov, lp, lv, W24'($urandom_range(0, 6 << FRAC_BITS)),
               W24'($urandom_range(1, 3 << FRAC_BITS)),
               W24'($urandom_range(0, 20 << FRAC_BITS)),
               W24'($urandom_range(0, 40 << FRAC_BITS)),
               W24'($urandom_range(1, 20 << FRAC_BITS)),
               W24'($urandom_range(0, 10 << FRAC_BITS)));
    end
  endtask

  task automatic run_phase(int count, int ring_m);
    for (int i = 0; i < count; i++) begin
      if (i == count / 3 && ring_m == 10000) hold_req = 1'b1;
      send_random(ring_m);
    end
    lower_valid();
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_TIME_STEP;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    own_position_i = '0;
    own_speed_i = '0;
    leader_position_i = '0;
    leader_speed_i = '0;
    body_length_i = '0;
    reaction_time_i = '0;
    brake_gain_i = '0;
    desired_speed_i = '0;
    steepness_i = '0;
    max_accel_i = '0;
    idle_cycles = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words at reset settings
    send_car(30'd0, 24'h7FFFFF, 30'h3FFFFFFF, 24'h800000, 24'hFFFFFF, 24'hFFFFFF,
             24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_car(30'h3FFFFFFF, 24'h800000, 30'd0, 24'h7FFFFF, 24'd0, 24'd1,
             24'd0, 24'd0, 24'd1, 24'hFFFFFF);
    // equal speeds
    send_car(30'd100 << 16, 24'd10 << 16, 30'd105 << 16, 24'd10 << 16, 24'd4 << 16,
             24'd2 << 16, 24'd5 << 16, 24'd20 << 16, 24'd3 << 16, 24'd2 << 16);
    // braking, then braking saturated
    send_car(30'd100 << 16, 24'd20 << 16, 30'd110 << 16, 24'd5 << 16, 24'd4 << 16,
             24'd2 << 16, 24'd5 << 16, 24'd20 << 16, 24'd3 << 16, 24'd2 << 16);
    send_car(30'd100 << 16, 24'd100 << 16, 30'd105 << 16, 24'd0, 24'd4 << 16,
             24'hFFFFFF, 24'hFFFFFF, 24'd20 << 16, 24'd3 << 16, 24'd2 << 16);
    // leader wrapped past ring end
    send_car(30'd9990 << 16, 24'd20 << 16, 30'd3 << 16, 24'd5 << 16, 24'd4 << 16,
             24'd2 << 16, 24'd5 << 16, 24'd20 << 16, 24'd3 << 16, 24'd2 << 16);
    // zero reaction time and zero steepness, then zero steepness alone
    send_car(30'd100 << 16, 24'd20 << 16, 30'd110 << 16, 24'd5 << 16, 24'd4 << 16,
             24'd0, 24'd5 << 16, 24'd30 << 16, 24'd0, 24'd3 << 16);
    send_car(30'd100 << 16, 24'd20 << 16, 30'd110 << 16, 24'd20 << 16, 24'd4 << 16,
             24'd1 << 16, 24'd5 << 16, 24'd20 << 16, 24'd0, 24'd3 << 16);
    // negative speed wraps below zero
    send_car(30'd0, 24'h800000, 30'd5 << 16, 24'h800000, 24'd0, 24'd1 << 16,
             24'd1, 24'd0, 24'd1, 24'hFFFFFF);
    // position just below ring end
    send_car(30'd9999 << 16, 24'd40 << 16, 30'd9999 << 16, 24'd40 << 16, 24'd0,
             24'd1 << 16, 24'd1, 24'd40 << 16, 24'd1 << 16, 24'd1 << 16);
    lower_valid();
    drain();

    run_phase(RAND_WORDS / 3, 10000);

    write_reg(REG_TIME_STEP, 24'hFFFFFF);
    write_reg(REG_RING_LENGTH, 24'd16383);
    write_reg(REG_SPARE, 24'd5);
    send_car(30'h3FFFFFFF, 24'h7FFFFF, 30'd0, 24'h800000, 24'd0, 24'd1,
             24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'hFFFFFF);
    send_car(30'd0, 24'h800000, 30'd0, 24'h7FFFFF, 24'd0, 24'hFFFFFF,
             24'hFFFFFF, 24'd0, 24'd1, 24'hFFFFFF);
    run_phase(RAND_WORDS / 4, 16383);

    write_reg(REG_TIME_STEP, 24'd1);
    write_reg(REG_RING_LENGTH, 24'd1);
    run_phase(RAND_WORDS / 6, 1);

    write_reg(REG_TIME_STEP, 24'd1677721);
    write_reg(REG_RING_LENGTH, 24'd500);
    run_phase(RAND_WORDS / 6, 500);

    quiet = 1'b1;
    run_phase(100, 500);

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
